[sv/adl_pkg.sv]
// Shared types, constants and helpers for the Adler-32 style checksum block.
// No dependencies; used by every module in sv/.
package adl_pkg;

	localparam int unsigned SUM_W  = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W  = 1;

	localparam logic [SUM_W-1:0] MODULUS = 16'd65521;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_SEED_LOW  = 1'b0;
	localparam logic [IDX_W-1:0] REG_SEED_HIGH = 1'b1;

	typedef struct packed {
		logic [SUM_W-1:0] low;
		logic [SUM_W-1:0] high;
	} adl_seeds_t;

	// One word leaving the input stage toward the running sums
	typedef struct packed {
		logic              advance;
		logic              last;
		logic [BYTE_W-1:0] data;
	} adl_step_t;

	// Single conditional subtract; input is below twice the modulus
	function automatic logic [SUM_W-1:0] fold(input logic [SUM_W:0] v);
		logic [SUM_W:0] m;
		m = {1'b0, MODULUS};
		if (v >= m) begin
			fold = SUM_W'(v - m);
		end else begin
			fold = v[SUM_W-1:0];
		end
	endfunction

endpackage

[sv/adl_cfg_regs.sv]
// Seed registers of the checksum block, written through the plain write port.
// Depends on adl_pkg.
module adl_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [adl_pkg::IDX_W-1:0]   cfg_index,
	input  logic [adl_pkg::SUM_W-1:0]   cfg_data,
	output adl_pkg::adl_seeds_t         seeds
);

	logic [adl_pkg::SUM_W-1:0] seed_low_q;
	logic [adl_pkg::SUM_W-1:0] seed_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				adl_pkg::REG_SEED_LOW:  seed_low_q  <= cfg_data;
				adl_pkg::REG_SEED_HIGH: seed_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign seeds.low  = seed_low_q;
	assign seeds.high = seed_high_q;

endmodule

[sv/adl_sum_unit.sv]
// Running low/high sums modulo 65521, one byte per step.
// Depends on adl_pkg.
module adl_sum_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  adl_pkg::adl_step_t          step,
	input  adl_pkg::adl_seeds_t         seeds,
	output logic [adl_pkg::SUM_W-1:0]   lo_next,
	output logic [adl_pkg::SUM_W-1:0]   hi_next
);

	logic [adl_pkg::SUM_W-1:0] sum_low_q;
	logic [adl_pkg::SUM_W-1:0] sum_high_q;

	always_comb begin
		lo_next = adl_pkg::fold({1'b0, sum_low_q} + {{(adl_pkg::SUM_W+1-adl_pkg::BYTE_W){1'b0}},
			step.data});
		hi_next = adl_pkg::fold({1'b0, sum_high_q} + {1'b0, lo_next});
	end

	// On the last byte the sums restart from the (folded) seeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q  <= '0;
			sum_high_q <= '0;
		end else if (step.advance) begin
			if (step.last) begin
				sum_low_q  <= adl_pkg::fold({1'b0, seeds.low});
				sum_high_q <= adl_pkg::fold({1'b0, seeds.high});
			end else begin
				sum_low_q  <= lo_next;
				sum_high_q <= hi_next;
			end
		end
	end

`ifndef SYNTH
	a_sums_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_low_q < adl_pkg::MODULUS && sum_high_q < adl_pkg::MODULUS)
		else $error("running sum reached the modulus");
	a_restart_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step.advance && step.last |=>
		sum_low_q == adl_pkg::fold({1'b0, $past(seeds.low)}))
		else $error("low sum not reloaded from seed after last word");
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step.advance |=> $stable(sum_low_q) && $stable(sum_high_q))
		else $error("sums moved without a word");
`endif

endmodule

[sv/adler32_checksum.sv]
// Top level of the Adler-32 style byte stream checksum.
// Depends on adl_pkg, adl_cfg_regs and adl_sum_unit.
//
// Usage:
//   Input channel (in_valid / in_stall, data_byte, last_byte) takes one
//   message byte per word; last_byte marks the final byte of a message.
//   Output channel (out_valid / out_stall, checksum) gives one word per
//   message: high sum in bits 31:16, low sum in bits 15:0.
//   Config port (cfg_wen, cfg_index, cfg_data) writes seed_low (index 0)
//   and seed_high (index 1). A new seed is loaded into the sums when a
//   last byte is folded in; the message in flight keeps its sums.
// Timing:
//   An accepted word sits in the input register and is then folded into the
//   sums; for a last byte the checksum enters the result register with that
//   same fold. Throughput is one byte per clock while in_stall is low, set
//   by the combinational add/fold of the low and high sums.
// Reset:
//   Seeds and both sums clear to zero; both stages come up empty.
// Stall:
//   A held checksum blocks only a further last byte; ordinary bytes keep
//   flowing past it, and in_stall rises only when the input register holds
//   a last byte that cannot move on.
module adler32_checksum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [adl_pkg::IDX_W-1:0]   cfg_index,
	input  logic [adl_pkg::SUM_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [adl_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2*adl_pkg::SUM_W-1:0] checksum
);

	adl_pkg::adl_seeds_t       seeds;
	adl_pkg::adl_step_t        step;
	logic [adl_pkg::SUM_W-1:0] lo_next;
	logic [adl_pkg::SUM_W-1:0] hi_next;

	// input register
	logic                       valid_s1;
	logic                       last_s1;
	logic [adl_pkg::BYTE_W-1:0] data_s1;

	// result register
	logic                          out_valid_q;
	logic [2*adl_pkg::SUM_W-1:0]   checksum_q;

	logic out_free;

	adl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seeds     (seeds)
	);

	// result slot can take a word if empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		step.advance = valid_s1 && (!last_s1 || out_free);
		step.last    = last_s1;
		step.data    = data_s1;
	end

	assign in_stall = valid_s1 && !step.advance;

	adl_sum_unit u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.seeds   (seeds),
		.lo_next (lo_next),
		.hi_next (hi_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step.advance && step.last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step.advance && step.last) begin
			checksum_q <= {hi_next, lo_next};
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

`ifndef SYNTH
	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		step.advance && step.last |=> out_valid && checksum == {$past(hi_next), $past(lo_next)})
		else $error("last word did not produce its checksum");
	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked last word");
	a_word_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step.advance && step.last))
		else $error("result word with no last byte behind it");
	a_halves_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> checksum[adl_pkg::SUM_W-1:0] < adl_pkg::MODULUS &&
		checksum[2*adl_pkg::SUM_W-1:adl_pkg::SUM_W] < adl_pkg::MODULUS)
		else $error("checksum half out of range");
`endif

endmodule
